// ===== src/assert_macros.svh =====
// Assertion helpers for the allocation accounting table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication on the same edge
`define AAT_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// Implication on the next edge
`define AAT_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants of the allocation accounting table.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int unsigned AddrBits      = 32;
  localparam int unsigned SizeBits      = 32;
  localparam int unsigned CompBits      = 3;
  localparam int unsigned CompIds       = 8;
  localparam int unsigned MaxComponents = 8;
  localparam int unsigned TableSlots    = 256;
  localparam logic [3:0]  NumCompReset  = 4'd8;

  localparam logic [2:0] ReqTrkAlloc = 3'd0;
  localparam logic [2:0] ReqTrkFree  = 3'd1;
  localparam logic [2:0] ReqUntAlloc = 3'd2;
  localparam logic [2:0] ReqUntFree  = 3'd3;
  localparam logic [2:0] ReqQuery    = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadComp  = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [AddrBits-1:0] addr;
    logic [SizeBits-1:0] size;
    logic [CompBits-1:0] owner;
  } slot_t;

endpackage

// ===== src/aat_cell.sv =====
// ----------------------------------------------------------------------------
// aat_cell
// One table slot; hands its entry to the neighbor while the ring turns.
// ----------------------------------------------------------------------------
module aat_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  aat_pkg::slot_t slot_i,
  output aat_pkg::slot_t slot_o
);

  aat_pkg::slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== src/allocation_accounting_table.sv =====
// ----------------------------------------------------------------------------
// allocation_accounting_table
// Per-component memory counters with a ring of tracked allocation slots.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  request  | start_i, busy_o, req_type_i..block_size_i | in
//  result   | done_o, status_o..peak_total_o            | out
//  config   | cfg_we_i, cfg_wdata_i                     | in
//
// Tracked alloc and free turn the slot ring once, one slot past the head per
// cycle; a tracked alloc with a bad component and all other requests finish
// without a scan. Reset empties all slots and counters at once. The result
// strobe lasts one cycle; busy_o stays high until it is shown.
// The receiver cannot stall; a new item may be taken while a result shows.
module allocation_accounting_table #(
  parameter int unsigned TABLE_SLOTS = aat_pkg::TableSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] address_i,
  input  logic [2:0]  component_i,
  input  logic [31:0] block_size_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [2:0]  touched_component_o,
  output logic [31:0] current_total_o,
  output logic [31:0] peak_total_o
);

  localparam int unsigned CntW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(TABLE_SLOTS - 1);

  typedef enum logic {IDLE, SCAN} state_e;

  state_e state_q;
  logic [CntW-1:0] cnt_q;
  logic [3:0] ncomp_q;
  logic [2:0] req_q, comp_q;
  logic [31:0] addr_q, size_q;
  logic found_q;
  logic [2:0] fown_q;
  logic [31:0] fsize_q;
  logic [31:0] tot_q [aat_pkg::CompIds];
  logic [31:0] pk_q [aat_pkg::CompIds];
  logic done_q;
  logic [1:0] status_q;
  logic [2:0] tc_q;
  logic [31:0] cur_q, peak_q;

  aat_pkg::slot_t ring [TABLE_SLOTS];
  aat_pkg::slot_t feed, head;

  logic shift, hit, found_now, is_alloc;
  logic [3:0] lim;
  logic [2:0] f_own, o;
  logic [31:0] f_size;

  assign head     = ring[0];
  assign shift    = (state_q == SCAN);
  assign is_alloc = (req_q == aat_pkg::ReqTrkAlloc);
  assign lim      = (ncomp_q > 4'(aat_pkg::MaxComponents)) ?
                    4'(aat_pkg::MaxComponents) : ncomp_q;

  always_comb begin
    if (is_alloc) begin
      hit = !found_q && (head.addr == '0);
    end else begin
      hit = !found_q && (addr_q != '0) && (head.addr == addr_q);
    end
    feed = head;
    if (hit) begin
      if (is_alloc) begin
        feed.addr  = addr_q;
        feed.size  = size_q;
        feed.owner = comp_q;
      end else begin
        feed = '0;
      end
    end
    found_now = found_q | hit;
    f_own  = hit ? head.owner : fown_q;
    f_size = hit ? head.size : fsize_q;
    o = (32'(f_own) >= aat_pkg::MaxComponents) ? 3'd0 : f_own;
  end

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_ring
    if (i == TABLE_SLOTS - 1) begin : g_last
      aat_cell u_cell (.clk_i, .rst_ni, .shift_i(shift), .slot_i(feed), .slot_o(ring[i]));
    end else begin : g_mid
      aat_cell u_cell (.clk_i, .rst_ni, .shift_i(shift), .slot_i(ring[i+1]),
                       .slot_o(ring[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      cnt_q    <= '0;
      ncomp_q  <= aat_pkg::NumCompReset;
      req_q    <= '0;
      comp_q   <= '0;
      addr_q   <= '0;
      size_q   <= '0;
      found_q  <= 1'b0;
      fown_q   <= '0;
      fsize_q  <= '0;
      done_q   <= 1'b0;
      status_q <= '0;
      tc_q     <= '0;
      cur_q    <= '0;
      peak_q   <= '0;
      for (int k = 0; k < aat_pkg::CompIds; k++) begin
        tot_q[k] <= '0;
        pk_q[k]  <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        ncomp_q <= cfg_wdata_i;
      end
      case (state_q)
        IDLE: begin
          if (start_i) begin
            req_q   <= req_type_i;
            comp_q  <= component_i;
            addr_q  <= address_i;
            size_q  <= block_size_i;
            found_q <= 1'b0;
            cnt_q   <= '0;
            if (req_type_i == aat_pkg::ReqTrkFree) begin
              state_q <= SCAN;
            end else if ({1'b0, component_i} >= lim) begin
              done_q   <= 1'b1;
              status_q <= aat_pkg::StBadComp;
              tc_q     <= component_i;
              cur_q    <= '0;
              peak_q   <= '0;
            end else if (req_type_i == aat_pkg::ReqTrkAlloc) begin
              tot_q[component_i] <= tot_q[component_i] + block_size_i;
              state_q <= SCAN;
            end else begin
              done_q   <= 1'b1;
              status_q <= aat_pkg::StOk;
              tc_q     <= component_i;
              cur_q    <= tot_q[component_i];
              peak_q   <= pk_q[component_i];
              if (req_type_i == aat_pkg::ReqUntAlloc) begin
                tot_q[component_i] <= tot_q[component_i] + block_size_i;
                cur_q <= tot_q[component_i] + block_size_i;
              end else if (req_type_i == aat_pkg::ReqUntFree) begin
                if (tot_q[component_i] > pk_q[component_i]) begin
                  pk_q[component_i] <= tot_q[component_i];
                  peak_q <= tot_q[component_i];
                end
                tot_q[component_i] <= tot_q[component_i] - block_size_i;
                cur_q <= tot_q[component_i] - block_size_i;
              end
            end
          end
        end
        SCAN: begin
          cnt_q   <= cnt_q + 1'b1;
          found_q <= found_now;
          fown_q  <= f_own;
          fsize_q <= f_size;
          if (cnt_q == LastCnt) begin
            state_q <= IDLE;
            done_q  <= 1'b1;
            if (is_alloc) begin
              status_q <= found_now ? aat_pkg::StOk : aat_pkg::StFull;
              tc_q     <= comp_q;
              cur_q    <= tot_q[comp_q];
              peak_q   <= pk_q[comp_q];
            end else if (found_now) begin
              status_q <= aat_pkg::StOk;
              tc_q     <= o;
              if (tot_q[o] > pk_q[o]) begin
                pk_q[o] <= tot_q[o];
                peak_q  <= tot_q[o];
              end else begin
                peak_q  <= pk_q[o];
              end
              tot_q[o] <= tot_q[o] - f_size;
              cur_q    <= tot_q[o] - f_size;
            end else begin
              status_q <= aat_pkg::StNotFound;
              tc_q     <= '0;
              cur_q    <= '0;
              peak_q   <= '0;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign busy_o              = (state_q != IDLE);
  assign done_o              = done_q;
  assign status_o            = status_q;
  assign touched_component_o = tc_q;
  assign current_total_o     = cur_q;
  assign peak_total_o        = peak_q;

`include "assert_macros.svh"

  `AAT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `AAT_ASSERT_NXT(a_free_scans, clk_i, rst_ni,
    start_i && !busy_o && (req_type_i == aat_pkg::ReqTrkFree), busy_o && !done_o)
  `AAT_ASSERT_IMP(a_full_alloc, clk_i, rst_ni, done_o && (status_o == aat_pkg::StFull),
    req_q == aat_pkg::ReqTrkAlloc)
  `AAT_ASSERT_IMP(a_nf_zero, clk_i, rst_ni, done_o && (status_o == aat_pkg::StNotFound),
    (current_total_o == '0) && (peak_total_o == '0))

endmodule

// ===== bench/allocation_accounting_table_tb.sv =====
// ----------------------------------------------------------------------------
// allocation_accounting_table_tb
// Drives tracked and untracked alloc/free and query items into the
// accounting table, predicts each result with a local copy of the slot table
// and counters, and compares every strobed result field by field.
// ----------------------------------------------------------------------------
module allocation_accounting_table_tb;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  comp;
    logic [31:0] cur;
    logic [31:0] peak;
  } acct_res_t;

  class acct_scoreboard;
    logic [31:0] slot_addr[aat_pkg::TableSlots];
    logic [31:0] slot_size[aat_pkg::TableSlots];
    logic [2:0]  slot_own[aat_pkg::TableSlots];
    logic [31:0] total[aat_pkg::MaxComponents];
    logic [31:0] peak[aat_pkg::MaxComponents];
    logic [3:0]  ncomp;
    acct_res_t   pending[$];
    int          live_addrs[$];
    int          errors;

    function void clear();
      for (int i = 0; i < aat_pkg::TableSlots; i++) begin
        slot_addr[i] = '0;
        slot_size[i] = '0;
        slot_own[i] = '0;
      end
      for (int c = 0; c < aat_pkg::MaxComponents; c++) begin
        total[c] = '0;
        peak[c] = '0;
      end
      ncomp = aat_pkg::NumCompReset;
      errors = 0;
    endfunction

    function void raise_peak(int c);
      if (total[c] > peak[c]) peak[c] = total[c];
    endfunction

    function void note_item(logic [2:0] req, logic [31:0] addr, logic [2:0] comp,
                            logic [31:0] size);
      acct_res_t r;
      int lim;
      bit hit;
      lim = (ncomp > aat_pkg::MaxComponents) ? aat_pkg::MaxComponents : ncomp;
      hit = 0;
      r = '{aat_pkg::StOk, comp, '0, '0};
      if (req == aat_pkg::ReqTrkFree) begin
        r = '{aat_pkg::StNotFound, 3'd0, '0, '0};
        if (addr != 0) begin
          for (int i = 0; i < aat_pkg::TableSlots && !hit; i++) begin
            if (slot_addr[i] == addr) begin
              hit = 1;
              raise_peak(slot_own[i]);
              total[slot_own[i]] -= slot_size[i];
              r = '{aat_pkg::StOk, slot_own[i], total[slot_own[i]], peak[slot_own[i]]};
              slot_addr[i] = '0;
              slot_size[i] = '0;
              slot_own[i] = '0;
            end
          end
        end
      end else if (comp >= lim) begin
        r.status = aat_pkg::StBadComp;
      end else begin
        if (req == aat_pkg::ReqTrkAlloc) begin
          total[comp] += size;
          r.status = aat_pkg::StFull;
          for (int i = 0; i < aat_pkg::TableSlots && !hit; i++) begin
            if (slot_addr[i] == 0) begin
              hit = 1;
              slot_addr[i] = addr;
              slot_size[i] = size;
              slot_own[i] = comp;
              r.status = aat_pkg::StOk;
            end
          end
        end else if (req == aat_pkg::ReqUntAlloc) begin
          total[comp] += size;
        end else if (req == aat_pkg::ReqUntFree) begin
          raise_peak(comp);
          total[comp] -= size;
        end
        r.cur = total[comp];
        r.peak = peak[comp];
      end
      pending.push_back(r);
    endfunction

    task check_result(acct_res_t got);
      acct_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report_mismatch($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.comp !== e.comp)
        report_mismatch($sformatf("component %0d exp %0d", got.comp, e.comp));
      if (got.cur !== e.cur)
        report_mismatch($sformatf("current %h exp %h", got.cur, e.cur));
      if (got.peak !== e.peak)
        report_mismatch($sformatf("peak %h exp %h", got.peak, e.peak));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        start_i = 0;
  logic        busy_o;
  logic [2:0]  req_type_i = '0;
  logic [31:0] address_i = '0;
  logic [2:0]  component_i = '0;
  logic [31:0] block_size_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [2:0]  touched_component_o;
  logic [31:0] current_total_o;
  logic [31:0] peak_total_o;

  acct_scoreboard sb = new();
  int unsigned cycles = 0;
  localparam int unsigned CycleLimit = 2000000;

  allocation_accounting_table dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{status_o, touched_component_o, current_total_o, peak_total_o});
  end

  task automatic send_item(logic [2:0] req, logic [31:0] addr, logic [2:0] comp,
                           logic [31:0] size);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1;
    req_type_i <= req;
    address_i <= addr;
    component_i <= comp;
    block_size_i <= size;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(req, addr, comp, size);
  endtask

  task automatic drain();
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [3:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.ncomp = v;
  endtask

  function automatic logic [31:0] pick_addr();
    if (sb.live_addrs.size() != 0 && $urandom_range(0, 2) != 0)
      return sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
    return $urandom_range(0, 15) == 0 ? 32'd0 : $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  task automatic random_items(int n, int alloc_bias);
    logic [2:0] req;
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      req = $urandom_range(0, 99) < alloc_bias ? aat_pkg::ReqTrkAlloc :
            3'($urandom_range(0, 7));
      a = pick_addr();
      if (req == aat_pkg::ReqTrkAlloc && a != 0) sb.live_addrs.push_back(a);
      send_item(req, a, 3'($urandom), pick_size());
    end
  endtask

  initial begin
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_item(aat_pkg::ReqTrkAlloc, 32'h1000, 3'd0, 32'hFFFF_FFFF);
    send_item(aat_pkg::ReqTrkAlloc, 32'hFFFF_FFFF, 3'd7, 32'd5);
    send_item(aat_pkg::ReqTrkAlloc, 32'd0, 3'd1, 32'd9);
    send_item(aat_pkg::ReqUntAlloc, 32'd0, 3'd0, 32'd2);
    send_item(aat_pkg::ReqTrkFree, 32'h1000, 3'd3, 32'd0);
    send_item(aat_pkg::ReqTrkFree, 32'h1000, 3'd3, 32'd0);
    send_item(aat_pkg::ReqTrkFree, 32'd0, 3'd0, 32'd0);
    send_item(aat_pkg::ReqUntFree, 32'd0, 3'd7, 32'd7);
    send_item(aat_pkg::ReqQuery, 32'd0, 3'd7, 32'd0);
    // unknown request types act as a query
    send_item(3'd5, 32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF);
    send_item(3'd7, 32'd0, 3'd1, 32'd0);
    write_cfg(4'd3);
    send_item(aat_pkg::ReqTrkAlloc, 32'h55, 3'd5, 32'd1);
    send_item(aat_pkg::ReqTrkFree, 32'hFFFF_FFFF, 3'd0, 32'd0);
    write_cfg(4'd0);
    send_item(aat_pkg::ReqQuery, 32'd0, 3'd0, 32'd0);
    write_cfg(4'd15);
    // fill the table to reach the full case
    for (int i = 0; i < aat_pkg::TableSlots + 2; i++)
      send_item(aat_pkg::ReqTrkAlloc, 32'h8000_0000 + i, 3'($urandom), $urandom);
    for (int i = 0; i < 64; i++)
      send_item(aat_pkg::ReqTrkFree, 32'h8000_0000 + 2 * i, 3'd0, 32'd0);
    random_items(100, 30);
    write_cfg(4'd1);
    random_items(80, 30);
    write_cfg(4'd8);
    random_items(100, 30);
    write_cfg(4'($urandom_range(2, 7)));
    random_items(60, 30);
    write_cfg(4'd9);
    random_items(80, 30);
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
